FILE: hdl/port_table_next_fit_allocator_core_assert.svh
// Assertion macros shared by the port table checker.
// Depends on nothing; included by the checker file by bare name.
`ifndef PORT_TABLE_NEXT_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define PORT_TABLE_NEXT_FIT_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTNF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("port table assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTNF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("port table assertion failed");

`endif

FILE: hdl/ptnf_pkg.sv
// Package for the port table allocator: sizes, codes, item types, helpers.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ptnf_pkg;

    localparam int PORTS_PER_KIND = 32768;
    localparam int ADDR_BITS      = 64;
    localparam int PORT_W         = 16;
    localparam int RADDR_W        = 64;
    localparam int REPLY_BASE     = 32768;
    localparam int IDX_W          = $clog2(PORTS_PER_KIND);
    localparam int WORD_W         = 32;
    localparam int BIT_W          = $clog2(WORD_W);
    localparam int WORDS          = PORTS_PER_KIND / WORD_W;
    localparam int WADDR_W        = $clog2(WORDS);
    localparam int VISIT_W        = $clog2(WORDS + 1);
    localparam int CUR_W          = $clog2(PORTS_PER_KIND + 1);

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        FN_OPEN_LISTEN = 2'd0,
        FN_OPEN_REPLY  = 2'd1,
        FN_REL_LISTEN  = 2'd2,
        FN_REL_REPLY   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        t_func               func;
        logic [PORT_W-1:0]   port_num;
        logic [RADDR_W-1:0]  remote_addr;
        logic [PORT_W-1:0]   remote_port;
    } t_req;

    typedef struct packed {
        logic [1:0]          status;
        logic [PORT_W-1:0]   granted_port;
        logic                already_open;
    } t_rsp;

    typedef struct packed {
        logic                we;
        logic [WADDR_W-1:0]  addr;
        logic [WORD_W-1:0]   wdata;
    } t_ram_req;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [IDX_W-1:0]     rport;
    } t_endpoint;

    // Position of the lowest set bit; zero when none is set.
    function automatic logic [BIT_W-1:0] low_pos(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] p;
        p = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                p = BIT_W'(i);
            end
        end
        return p;
    endfunction

endpackage

FILE: hdl/ptnf_map_ram.sv
// Word-wide bitmap memory, one port, registered read data.
// Depends on ptnf_pkg for sizes and the request struct.
`timescale 1ns / 1ps

module ptnf_map_ram (
    input  logic                        i_clk,
    input  ptnf_pkg::t_ram_req          i_req,
    output logic [ptnf_pkg::WORD_W-1:0] o_rdata
);

    logic [ptnf_pkg::WORD_W-1:0] r_mem [ptnf_pkg::WORDS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.addr];
    end

endmodule

FILE: hdl/port_table_next_fit_allocator_core.sv
// Top level of the port table allocator: control, scan and endpoint store.
// Depends on ptnf_pkg and ptnf_map_ram.
`timescale 1ns / 1ps

// Port table engine. Present an item on i_req with start high; it is taken at
// a clock edge where busy is low. Exactly one result follows, shown on o_rsp
// for one cycle with o_done high; it cannot be held off, so sample it then.
// After reset the block sweeps both usage bitmaps clear, one 32-bit word per
// cycle, with busy high. Listen opens and both releases go from acceptance
// through the execute state, with busy high, to the registered o_done.
// Open-reply scans the reply bitmap one word per cycle from the cursor, with
// busy high, passing over fully used words until it finds a free bit or, when
// the map is full, has revisited the cursor's word, through the single read port.
module port_table_next_fit_allocator_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  ptnf_pkg::t_req   i_req,
    output logic             busy,
    output logic             o_done,
    output ptnf_pkg::t_rsp   o_rsp
);

    localparam int PW1 = ptnf_pkg::PORT_W + 1;

    ptnf_pkg::t_state                 r_state, n_state;
    logic [ptnf_pkg::WADDR_W-1:0]     r_clr_addr, n_clr_addr;
    ptnf_pkg::t_req                   r_req;
    logic [ptnf_pkg::WADDR_W-1:0]     r_ptr, n_ptr;
    logic [ptnf_pkg::BIT_W-1:0]       r_bit, n_bit;
    logic [ptnf_pkg::VISIT_W-1:0]     r_visits, n_visits;
    logic [ptnf_pkg::CUR_W-1:0]       r_cursor, n_cursor;
    logic                             r_done, n_done;
    ptnf_pkg::t_rsp                   r_rsp, n_rsp;

    logic                             w_accept;
    logic                             w_fin;
    ptnf_pkg::t_ram_req               w_lreq, w_rreq;
    logic [ptnf_pkg::WORD_W-1:0]      w_lrd, w_rrd;

    logic [ptnf_pkg::IDX_W-1:0]       w_start_idx;
    logic [ptnf_pkg::IDX_W-1:0]       w_in_idx;
    logic                             w_lbad, w_rbad, w_rport_bad;
    logic [ptnf_pkg::WORD_W-1:0]      w_hot, w_below, w_mask, w_free, w_pos_hot;
    logic [ptnf_pkg::BIT_W-1:0]       w_pos;
    logic [ptnf_pkg::IDX_W-1:0]       w_found_idx;

    // Remote endpoint of each reply port; written on grant, never cleared.
    ptnf_pkg::t_endpoint              r_ep_mem [ptnf_pkg::PORTS_PER_KIND];
    logic                             w_ep_we;

    ptnf_map_ram u_listen_map (
        .i_clk   (i_clk),
        .i_req   (w_lreq),
        .o_rdata (w_lrd)
    );

    ptnf_map_ram u_reply_map (
        .i_clk   (i_clk),
        .i_req   (w_rreq),
        .o_rdata (w_rrd)
    );

    assign busy     = (r_state != ptnf_pkg::S_IDLE);
    assign w_accept = start && (r_state == ptnf_pkg::S_IDLE);
    assign o_done   = r_done;
    assign o_rsp    = r_rsp;

    // Decode the incoming item into a bitmap index; a stale cursor past the
    // top restarts the scan at the bottom.
    always_comb begin
        w_start_idx = (r_cursor >= ptnf_pkg::CUR_W'(ptnf_pkg::PORTS_PER_KIND))
                      ? '0 : r_cursor[ptnf_pkg::IDX_W-1:0];
        case (i_req.func)
            ptnf_pkg::FN_OPEN_REPLY: begin
                w_in_idx = w_start_idx;
            end
            ptnf_pkg::FN_REL_REPLY: begin
                w_in_idx = ptnf_pkg::IDX_W'(PW1'(i_req.port_num)
                                            - PW1'(ptnf_pkg::REPLY_BASE));
            end
            default: begin
                w_in_idx = i_req.port_num[ptnf_pkg::IDX_W-1:0];
            end
        endcase
    end

    // Range checks and the free-bit search on the word just read.
    always_comb begin
        w_lbad      = r_req.port_num >= ptnf_pkg::PORT_W'(ptnf_pkg::PORTS_PER_KIND);
        w_rbad      = (PW1'(r_req.port_num) < PW1'(ptnf_pkg::REPLY_BASE))
                   || ((PW1'(r_req.port_num) - PW1'(ptnf_pkg::REPLY_BASE))
                       >= PW1'(ptnf_pkg::PORTS_PER_KIND));
        w_rport_bad = r_req.remote_port >= ptnf_pkg::PORT_W'(ptnf_pkg::PORTS_PER_KIND);
        w_hot       = ptnf_pkg::WORD_W'(1) << r_bit;
        w_below     = w_hot - ptnf_pkg::WORD_W'(1);
        // First visit looks at or above the cursor bit, the wrap-around
        // revisit of the same word only below it.
        if (r_visits == '0) begin
            w_mask = ~w_below;
        end else if (r_visits == ptnf_pkg::VISIT_W'(ptnf_pkg::WORDS)) begin
            w_mask = w_below;
        end else begin
            w_mask = '1;
        end
        w_free      = ~w_rrd & w_mask;
        w_pos       = ptnf_pkg::low_pos(w_free);
        w_pos_hot   = ptnf_pkg::WORD_W'(1) << w_pos;
        w_found_idx = {r_ptr, w_pos};
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptnf_pkg::S_CLEAR: begin
                if (r_clr_addr == ptnf_pkg::WADDR_W'(ptnf_pkg::WORDS - 1)) begin
                    n_state = ptnf_pkg::S_IDLE;
                end
            end
            ptnf_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = ptnf_pkg::S_EXEC;
                end
            end
            ptnf_pkg::S_EXEC: begin
                if (w_fin) begin
                    n_state = ptnf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ptnf_pkg::S_CLEAR;
            end
        endcase
    end

    // Outputs: memory requests, scan bookkeeping and the result.
    always_comb begin
        w_lreq.we    = 1'b0;
        w_lreq.addr  = r_ptr;
        w_lreq.wdata = w_lrd;
        w_rreq.we    = 1'b0;
        w_rreq.addr  = r_ptr;
        w_rreq.wdata = w_rrd;
        w_ep_we      = 1'b0;
        w_fin        = 1'b0;
        n_clr_addr   = r_clr_addr;
        n_ptr        = r_ptr;
        n_bit        = r_bit;
        n_visits     = r_visits;
        n_cursor     = r_cursor;
        n_rsp        = '0;
        case (r_state)
            ptnf_pkg::S_CLEAR: begin
                w_lreq.we    = 1'b1;
                w_lreq.addr  = r_clr_addr;
                w_lreq.wdata = '0;
                w_rreq.we    = 1'b1;
                w_rreq.addr  = r_clr_addr;
                w_rreq.wdata = '0;
                n_clr_addr   = r_clr_addr + ptnf_pkg::WADDR_W'(1);
            end
            ptnf_pkg::S_IDLE: begin
                // Read the word of the item's port so it is ready next cycle.
                w_lreq.addr = w_in_idx[ptnf_pkg::IDX_W-1:ptnf_pkg::BIT_W];
                w_rreq.addr = w_in_idx[ptnf_pkg::IDX_W-1:ptnf_pkg::BIT_W];
                if (w_accept) begin
                    n_ptr    = w_in_idx[ptnf_pkg::IDX_W-1:ptnf_pkg::BIT_W];
                    n_bit    = w_in_idx[ptnf_pkg::BIT_W-1:0];
                    n_visits = '0;
                end
            end
            ptnf_pkg::S_EXEC: begin
                case (r_req.func)
                    ptnf_pkg::FN_OPEN_LISTEN: begin
                        w_fin = 1'b1;
                        if (w_lbad) begin
                            n_rsp.status = ptnf_pkg::ST_RANGE;
                        end else begin
                            n_rsp.status       = ptnf_pkg::ST_OK;
                            n_rsp.granted_port = r_req.port_num;
                            n_rsp.already_open = |(w_lrd & w_hot);
                            w_lreq.we          = 1'b1;
                            w_lreq.wdata       = w_lrd | w_hot;
                        end
                    end
                    ptnf_pkg::FN_REL_LISTEN: begin
                        w_fin = 1'b1;
                        if (w_lbad) begin
                            n_rsp.status = ptnf_pkg::ST_RANGE;
                        end else begin
                            n_rsp.status       = ptnf_pkg::ST_OK;
                            n_rsp.granted_port = r_req.port_num;
                            w_lreq.we          = 1'b1;
                            w_lreq.wdata       = w_lrd & ~w_hot;
                        end
                    end
                    ptnf_pkg::FN_REL_REPLY: begin
                        w_fin = 1'b1;
                        if (w_rbad) begin
                            n_rsp.status = ptnf_pkg::ST_RANGE;
                        end else begin
                            n_rsp.status       = ptnf_pkg::ST_OK;
                            n_rsp.granted_port = r_req.port_num;
                            w_rreq.we          = 1'b1;
                            w_rreq.wdata       = w_rrd & ~w_hot;
                        end
                    end
                    ptnf_pkg::FN_OPEN_REPLY: begin
                        if (|w_free) begin
                            // Found: advance the cursor past it, then check
                            // the remote port before claiming the entry.
                            w_fin    = 1'b1;
                            n_cursor = ptnf_pkg::CUR_W'(w_found_idx)
                                     + ptnf_pkg::CUR_W'(1);
                            if (w_rport_bad) begin
                                n_rsp.status = ptnf_pkg::ST_RANGE;
                            end else begin
                                n_rsp.status       = ptnf_pkg::ST_OK;
                                n_rsp.granted_port = ptnf_pkg::PORT_W'(ptnf_pkg::REPLY_BASE)
                                                   + ptnf_pkg::PORT_W'(w_found_idx);
                                w_rreq.we          = 1'b1;
                                w_rreq.wdata       = w_rrd | w_pos_hot;
                                w_ep_we            = 1'b1;
                            end
                        end else if (r_visits == ptnf_pkg::VISIT_W'(ptnf_pkg::WORDS)) begin
                            w_fin        = 1'b1;
                            n_rsp.status = ptnf_pkg::ST_FULL;
                        end else begin
                            // Word fully used: read the next one, wrapping.
                            n_ptr       = r_ptr + ptnf_pkg::WADDR_W'(1);
                            n_visits    = r_visits + ptnf_pkg::VISIT_W'(1);
                            w_lreq.addr = n_ptr;
                            w_rreq.addr = n_ptr;
                        end
                    end
                    default: begin
                        w_fin = 1'b1;
                    end
                endcase
            end
            default: begin
            end
        endcase
        n_done = w_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ptnf_pkg::S_CLEAR;
            r_clr_addr <= '0;
            r_ptr      <= '0;
            r_bit      <= '0;
            r_visits   <= '0;
            r_cursor   <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_ptr      <= n_ptr;
            r_bit      <= n_bit;
            r_visits   <= n_visits;
            r_cursor   <= n_cursor;
            r_done     <= n_done;
        end
    end

    // Hold the accepted item and the result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        r_rsp <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (w_ep_we) begin
            r_ep_mem[w_found_idx] <= '{
                addr:  r_req.remote_addr[ptnf_pkg::ADDR_BITS-1:0],
                rport: r_req.remote_port[ptnf_pkg::IDX_W-1:0]
            };
        end
    end

endmodule

FILE: hdl/ptnf_checker.sv
// Port-level checker for the port table allocator, bound to the top level.
// Depends on ptnf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "port_table_next_fit_allocator_core_assert.svh"

module ptnf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_done,
    input ptnf_pkg::t_rsp o_rsp
);

    // An accepted item keeps the engine busy in the next cycle, with no result yet.
    `PTNF_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_done)

    // A result is only shown after the engine was busy.
    `PTNF_ASSERT_IMP(a_done_after_busy, i_clk, i_rst_n, o_done, $past(busy))

    // Errors carry zero port and no already-open flag.
    `PTNF_ASSERT_IMP(a_err_clean, i_clk, i_rst_n,
        o_done && (o_rsp.status != ptnf_pkg::ST_OK),
        (o_rsp.granted_port == '0) && !o_rsp.already_open)

    // Already-open is only reported for a good listening port.
    `PTNF_ASSERT_IMP(a_again_listen, i_clk, i_rst_n,
        o_done && o_rsp.already_open,
        (o_rsp.status == ptnf_pkg::ST_OK) && !o_rsp.granted_port[ptnf_pkg::PORT_W-1])

endmodule

bind port_table_next_fit_allocator_core ptnf_checker u_ptnf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

FILE: tb/sv/tb_port_table_next_fit_allocator_core.sv
// Self-checking testbench for the port table next-fit allocator core.
// Depends on ptnf_pkg and the port_table_next_fit_allocator_core RTL.
// A behavioral predictor runs alongside the block, and each result is checked.
`timescale 1ns / 1ps

module tb_port_table_next_fit_allocator_core;

    // An open-reply may scan the whole reply map, so the limit allows such a scan
    // for every item, several times over.
    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int RANDOM_ITEMS  = 750;
    localparam int MAX_REPORTS   = 10;
    localparam int TAIL_CYCLES   = 1100;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    ptnf_pkg::t_req i_req;
    logic busy;
    logic o_done;
    ptnf_pkg::t_rsp o_rsp;

    // Predictor state: the usage maps and the next-fit cursor.
    bit          listen_map [ptnf_pkg::PORTS_PER_KIND];
    bit          reply_map  [ptnf_pkg::PORTS_PER_KIND];
    int unsigned reply_cursor;
    int          reply_in_use;
    logic [15:0] granted_replies [$];

    // Results in flight, oldest first.
    ptnf_pkg::t_rsp pending_rsp [$];

    int          cycle_count;
    int          mismatch_count;
    int          items_sent;
    int          results_seen;
    int          n_ok, n_range, n_full, n_again;
    bit          idle_off;

    port_table_next_fit_allocator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Compute the expected result of one item and advance the predictor state.
    function automatic ptnf_pkg::t_rsp predict_port_op(input ptnf_pkg::t_req req);
        ptnf_pkg::t_rsp r;
        int unsigned    first;
        int unsigned    slot;
        int unsigned    idx;
        bit             found;
        r = '0;
        r.status = ptnf_pkg::ST_OK;
        case (req.func)
            ptnf_pkg::FN_OPEN_LISTEN: begin
                if (req.port_num >= ptnf_pkg::PORTS_PER_KIND) begin
                    r.status = ptnf_pkg::ST_RANGE;
                end else begin
                    r.granted_port = req.port_num;
                    r.already_open = listen_map[req.port_num];
                    listen_map[req.port_num] = 1'b1;
                end
            end
            ptnf_pkg::FN_OPEN_REPLY: begin
                // Next fit: start at the cursor, wrap at the top of the map.
                first = (reply_cursor >= ptnf_pkg::PORTS_PER_KIND) ? 0 : reply_cursor;
                found = 1'b0;
                slot = 0;
                for (int unsigned n = 0; n < ptnf_pkg::PORTS_PER_KIND && !found; n++) begin
                    slot = (first + n) % ptnf_pkg::PORTS_PER_KIND;
                    if (!reply_map[slot]) begin
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    r.status = ptnf_pkg::ST_FULL;
                end else begin
                    // Advance the cursor even when the remote port is bad.
                    reply_cursor = slot + 1;
                    if (req.remote_port >= ptnf_pkg::PORTS_PER_KIND) begin
                        r.status = ptnf_pkg::ST_RANGE;
                    end else begin
                        reply_map[slot] = 1'b1;
                        reply_in_use++;
                        r.granted_port = 16'(ptnf_pkg::REPLY_BASE + slot);
                        granted_replies.push_back(r.granted_port);
                    end
                end
            end
            ptnf_pkg::FN_REL_LISTEN: begin
                if (req.port_num >= ptnf_pkg::PORTS_PER_KIND) begin
                    r.status = ptnf_pkg::ST_RANGE;
                end else begin
                    listen_map[req.port_num] = 1'b0;
                    r.granted_port = req.port_num;
                end
            end
            default: begin
                idx = int'(req.port_num) - ptnf_pkg::REPLY_BASE;
                if (req.port_num < ptnf_pkg::REPLY_BASE
                    || idx >= ptnf_pkg::PORTS_PER_KIND) begin
                    r.status = ptnf_pkg::ST_RANGE;
                end else begin
                    if (reply_map[idx]) begin
                        reply_in_use--;
                    end
                    reply_map[idx] = 1'b0;
                    r.granted_port = req.port_num;
                end
            end
        endcase
        return r;
    endfunction

    function automatic ptnf_pkg::t_req port_req(input ptnf_pkg::t_func f, input int port,
                                                input logic [63:0] addr, input int rport);
        ptnf_pkg::t_req r;
        r.func        = f;
        r.port_num    = 16'(port);
        r.remote_addr = addr;
        r.remote_port = 16'(rport);
        return r;
    endfunction

    // Present one item at the falling edge and hold it until the block takes it.
    // Return at a falling edge with start still high, so a following item goes
    // out back to back; the caller lowers start when nothing follows.
    task automatic send_item(input ptnf_pkg::t_req item);
        ptnf_pkg::t_rsp want;
        if (!idle_off && $urandom_range(99) < 15) begin
            start = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        i_req = item;
        start = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        want = predict_port_op(item);
        pending_rsp.push_back(want);
        items_sent++;
        case (want.status)
            ptnf_pkg::ST_OK:    n_ok++;
            ptnf_pkg::ST_RANGE: n_range++;
            default:            n_full++;
        endcase
        if (want.already_open) begin
            n_again++;
        end
        @(negedge i_clk);
    endtask

    task automatic flag_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_count, what, want, got);
        end
    endtask

    // Check every result against the oldest expectation. The receiver cannot
    // stall, so sample o_rsp on each rising edge where o_done is high.
    always @(posedge i_clk) begin
        ptnf_pkg::t_rsp want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            results_seen++;
            if (pending_rsp.size() == 0) begin
                flag_mismatch("unexpected result, status", -1, int'(o_rsp.status));
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.status !== want.status) begin
                    flag_mismatch("status", want.status, o_rsp.status);
                end
                if (o_rsp.granted_port !== want.granted_port) begin
                    flag_mismatch("granted_port", want.granted_port, o_rsp.granted_port);
                end
                if (o_rsp.already_open !== want.already_open) begin
                    flag_mismatch("already_open", want.already_open, o_rsp.already_open);
                end
            end
        end
    end

    // Watchdog: end the run if the block stops answering.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_rsp.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Listen ports: both ends of the range, out-of-range numbers, reopening a
    // port in use and releasing a free one.
    task automatic test_listen_ports();
        send_item(port_req(ptnf_pkg::FN_OPEN_LISTEN, 0,     64'h0, 0));
        send_item(port_req(ptnf_pkg::FN_OPEN_LISTEN, 32767, 64'h0, 0));
        send_item(port_req(ptnf_pkg::FN_OPEN_LISTEN, 0,     64'h0, 0));
        send_item(port_req(ptnf_pkg::FN_OPEN_LISTEN, 32768, 64'h0, 0));
        send_item(port_req(ptnf_pkg::FN_OPEN_LISTEN, 65535, 64'h0, 0));
        send_item(port_req(ptnf_pkg::FN_REL_LISTEN,  32768, 64'h0, 0));
        send_item(port_req(ptnf_pkg::FN_REL_LISTEN,  65535, 64'h0, 0));
        send_item(port_req(ptnf_pkg::FN_REL_LISTEN,  0,     64'h0, 0));
        send_item(port_req(ptnf_pkg::FN_REL_LISTEN,  0,     64'h0, 0));
        send_item(port_req(ptnf_pkg::FN_OPEN_LISTEN, 0,     64'h0, 0));
    endtask

    // Reply ports: remote port at its limits, a bad remote port that moves the
    // cursor past a free entry, and releases inside and outside the range.
    task automatic test_reply_ports();
        send_item(port_req(ptnf_pkg::FN_OPEN_REPLY, 0,     64'hFFFF_FFFF_FFFF_FFFF, 0));
        send_item(port_req(ptnf_pkg::FN_OPEN_REPLY, 65535, 64'h0, 32767));
        send_item(port_req(ptnf_pkg::FN_OPEN_REPLY, 0,     64'h5A5A_0000_A5A5_FFFF, 32768));
        send_item(port_req(ptnf_pkg::FN_OPEN_REPLY, 0,     64'h1, 65535));
        send_item(port_req(ptnf_pkg::FN_OPEN_REPLY, 12345, 64'h8000_0000_0000_0000, 100));
        send_item(port_req(ptnf_pkg::FN_REL_REPLY,  32770, 64'h0, 0));
        send_item(port_req(ptnf_pkg::FN_REL_REPLY,  32767, 64'h0, 0));
        send_item(port_req(ptnf_pkg::FN_REL_REPLY,  0,     64'h0, 0));
        send_item(port_req(ptnf_pkg::FN_REL_REPLY,  65535, 64'h0, 0));
        send_item(port_req(ptnf_pkg::FN_REL_REPLY,  32768, 64'h0, 0));
        send_item(port_req(ptnf_pkg::FN_OPEN_REPLY, 0,     64'h0, 0));
    endtask

    // Random mix: mostly well-formed opens and releases on a small set of
    // ports so that collisions and reuse happen, plus noise over full fields.
    task automatic test_random_mix();
        ptnf_pkg::t_req r;
        int unsigned    pick;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // Hold a long stretch back to back.
            idle_off = (i >= 250 && i < 400);
            pick = $urandom_range(99);
            r.func        = ptnf_pkg::t_func'($urandom_range(3));
            r.remote_addr = {$urandom, $urandom};
            r.remote_port = ($urandom_range(99) < 85) ? 16'($urandom_range(32767))
                                                      : 16'($urandom_range(65535, 32768));
            case (r.func)
                ptnf_pkg::FN_OPEN_LISTEN, ptnf_pkg::FN_REL_LISTEN: begin
                    if (pick < 75) begin
                        r.port_num = 16'($urandom_range(47));
                    end else if (pick < 85) begin
                        r.port_num = 16'(32767 - $urandom_range(3));
                    end else begin
                        r.port_num = 16'($urandom);
                    end
                end
                ptnf_pkg::FN_REL_REPLY: begin
                    if (pick < 60 && granted_replies.size() > 0) begin
                        r.port_num = granted_replies[$urandom_range(granted_replies.size() - 1)];
                    end else if (pick < 80) begin
                        r.port_num = 16'(ptnf_pkg::REPLY_BASE + $urandom_range(63));
                    end else begin
                        r.port_num = 16'($urandom);
                    end
                end
                default: begin
                    r.port_num = 16'($urandom);
                end
            endcase
            send_item(r);
        end
        idle_off = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        idle_off = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // The clearing pass after reset shows as busy; send_item waits it out.
        test_listen_ports();
        test_reply_ports();
        test_random_mix();

        // Drop start, drain outstanding results, then watch for stray ones.
        start = 1'b0;
        while (pending_rsp.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_rsp.size() != 0) begin
            mismatch_count++;
        end

        $display("covered %0d items and %0d results in %0d cycles, %0d mismatches",
                 items_sent, results_seen, cycle_count, mismatch_count);
        $display("  ok %0d (reopened listen %0d), range errors %0d, map full %0d, %0d held",
                 n_ok, n_again, n_range, n_full, reply_in_use);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
